FILE: design/hmq_pkg.sv
// hmq_pkg: shared sizes, codes and word types for the binary min-heap queue
// used by the controller, the datapath and the top level; depends on nothing
package hmq_pkg;

   localparam int CAPACITY  = 1024;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int COUNT_W   = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_EXTRACT = 2'd1;
   localparam logic [1:0] CMD_PEEK    = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // read slot select
   localparam logic [2:0] RD_ROOT   = 3'd0;
   localparam logic [2:0] RD_PARENT = 3'd1;
   localparam logic [2:0] RD_LAST   = 3'd2;
   localparam logic [2:0] RD_LEFT   = 3'd3;
   localparam logic [2:0] RD_RIGHT  = 3'd4;

   // write data select
   localparam logic [1:0] WR_MOV  = 2'd0;
   localparam logic [1:0] WR_RAM  = 2'd1;
   localparam logic [1:0] WR_CVAL = 2'd2;

   typedef struct packed {
      logic [1:0]                  cmd;
      logic signed [KEY_WIDTH-1:0] key_in;
   } req_word_type;

   typedef struct packed {
      logic signed [KEY_WIDTH-1:0] key_out;
      logic [COUNT_W-1:0]          count_out;
      logic [1:0]                  status;
   } rsp_word_type;

   typedef struct packed {
      logic       accept;
      logic       ld_insert;
      logic       ld_extract;
      logic       set_result;
      logic [1:0] result_status;
      logic       result_from_ram;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic       pos_parent;
      logic       pos_child;
      logic       cval_ld;
      logic       cval_right;
      logic       load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       empty;
      logic       at_root;
      logic       parent_le;
      logic       no_child;
      logic       has_right;
      logic       right_lt;
      logic       child_ge;
      logic       out_free;
   } dp_status_type;

endpackage

FILE: design/hmq_ram.sv
// hmq_ram: generic simple dual-port RAM, one write and one registered read port
// standalone, no package needed
module hmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hmq_datapath.sv
// hmq_datapath: heap store, count, sift position, moving key and result register
// depends on hmq_pkg and hmq_ram; driven by hmq_controller commands
module hmq_datapath import hmq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_word,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word,
   input  logic          rsp_stall
);

   req_word_type                req_ff, req_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic [COUNT_W-1:0]          pos_ff, pos_in;
   logic [COUNT_W-1:0]          cidx_ff, cidx_in;
   logic signed [KEY_WIDTH-1:0] mov_ff, mov_in;
   logic signed [KEY_WIDTH-1:0] cval_ff, cval_in;
   logic signed [KEY_WIDTH-1:0] res_key_ff, res_key_in;
   logic [1:0]                  res_status_ff, res_status_in;
   rsp_word_type                rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic signed [KEY_WIDTH-1:0] rd_data;
   logic [KEY_WIDTH-1:0]        rd_data_raw;
   logic [KEY_WIDTH-1:0]        wr_data;
   logic [COUNT_W-1:0]          rd_slot, rd_slot_m1, wr_slot_m1;
   logic [COUNT_W:0]            left_slot, right_slot;
   logic                        out_free;

   assign rd_data    = rd_data_raw;
   assign left_slot  = {pos_ff, 1'b0};
   assign right_slot = {pos_ff, 1'b1};
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (dp_cmd.rd_sel)
         RD_ROOT:   rd_slot = COUNT_W'(1);
         RD_PARENT: rd_slot = pos_ff >> 1;
         RD_LAST:   rd_slot = count_ff;
         RD_LEFT:   rd_slot = left_slot[COUNT_W-1:0];
         RD_RIGHT:  rd_slot = right_slot[COUNT_W-1:0];
         default:   rd_slot = COUNT_W'(1);
      endcase
      case (dp_cmd.wr_sel)
         WR_MOV:  wr_data = mov_ff;
         WR_RAM:  wr_data = rd_data;
         WR_CVAL: wr_data = cval_ff;
         default: wr_data = mov_ff;
      endcase
   end

   // slot n lives at address n-1
   assign rd_slot_m1 = rd_slot - COUNT_W'(1);
   assign wr_slot_m1 = pos_ff - COUNT_W'(1);

   hmq_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.wr_en),
      .wr_addr (wr_slot_m1[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (dp_cmd.rd_en),
      .rd_addr (rd_slot_m1[ADDR_W-1:0]),
      .rd_data (rd_data_raw)
   );

   always_comb begin
      req_in        = req_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      cidx_in       = cidx_ff;
      mov_in        = mov_ff;
      cval_in       = cval_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (dp_cmd.accept) begin
         req_in = req_word;
      end
      if (dp_cmd.ld_insert) begin
         count_in = count_ff + COUNT_W'(1);
         pos_in   = count_ff + COUNT_W'(1);
         mov_in   = req_ff.key_in;
      end
      if (dp_cmd.ld_extract) begin
         count_in = count_ff - COUNT_W'(1);
         pos_in   = COUNT_W'(1);
         mov_in   = rd_data;
      end
      if (dp_cmd.set_result) begin
         res_status_in = dp_cmd.result_status;
         res_key_in    = dp_cmd.result_from_ram ? rd_data : '0;
      end
      if (dp_cmd.pos_parent) begin
         pos_in = pos_ff >> 1;
      end
      if (dp_cmd.pos_child) begin
         pos_in = cidx_ff;
      end
      if (dp_cmd.cval_ld) begin
         cval_in = rd_data;
         cidx_in = dp_cmd.cval_right ? right_slot[COUNT_W-1:0] : left_slot[COUNT_W-1:0];
      end
      if (dp_cmd.load_rsp) begin
         rsp_in.key_out   = res_key_ff;
         rsp_in.count_out = count_ff;
         rsp_in.status    = res_status_ff;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      pos_ff        <= pos_in;
      cidx_ff       <= cidx_in;
      mov_ff        <= mov_in;
      cval_ff       <= cval_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      dp_status.cmd       = req_ff.cmd;
      dp_status.full      = count_ff >= COUNT_W'(CAPACITY);
      dp_status.empty     = count_ff == '0;
      dp_status.at_root   = pos_ff == COUNT_W'(1);
      dp_status.parent_le = rd_data <= mov_ff;
      dp_status.no_child  = left_slot > {1'b0, count_ff};
      dp_status.has_right = left_slot < {1'b0, count_ff};
      dp_status.right_lt  = rd_data < cval_ff;
      dp_status.child_ge  = cval_ff >= mov_ff;
      dp_status.out_free  = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

FILE: design/hmq_controller.sv
// hmq_controller: state machine sequencing decode, sift-up and sift-down
// depends on hmq_pkg; drives hmq_datapath through dp_cmd_type
module hmq_controller import hmq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_UP_RD    = 4'd2;
   localparam logic [3:0] S_UP_CMP   = 4'd3;
   localparam logic [3:0] S_ROOT     = 4'd4;
   localparam logic [3:0] S_LAST     = 4'd5;
   localparam logic [3:0] S_DN_RD    = 4'd6;
   localparam logic [3:0] S_DN_LEFT  = 4'd7;
   localparam logic [3:0] S_DN_RIGHT = 4'd8;
   localparam logic [3:0] S_DN_CMP   = 4'd9;
   localparam logic [3:0] S_RESP     = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.accept = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            dp_cmd.set_result = 1'b1;
            case (dp_status.cmd)
               CMD_INSERT: begin
                  if (dp_status.full) begin
                     dp_cmd.result_status = ST_FULL;
                     state_in             = S_RESP;
                  end else begin
                     dp_cmd.result_status = ST_OK;
                     dp_cmd.ld_insert     = 1'b1;
                     state_in             = S_UP_RD;
                  end
               end
               CMD_EXTRACT, CMD_PEEK: begin
                  if (dp_status.empty) begin
                     dp_cmd.result_status = ST_EMPTY;
                     state_in             = S_RESP;
                  end else begin
                     dp_cmd.result_status = ST_OK;
                     dp_cmd.rd_en         = 1'b1;
                     dp_cmd.rd_sel        = RD_ROOT;
                     state_in             = S_ROOT;
                  end
               end
               default: begin
                  dp_cmd.result_status = ST_OK;
                  state_in             = S_RESP;
               end
            endcase
         end
         S_UP_RD: begin
            if (dp_status.at_root) begin
               dp_cmd.wr_en  = 1'b1;
               dp_cmd.wr_sel = WR_MOV;
               state_in      = S_RESP;
            end else begin
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.rd_sel = RD_PARENT;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            dp_cmd.wr_en = 1'b1;
            if (dp_status.parent_le) begin
               dp_cmd.wr_sel = WR_MOV;
               state_in      = S_RESP;
            end else begin
               dp_cmd.wr_sel     = WR_RAM;
               dp_cmd.pos_parent = 1'b1;
               state_in          = S_UP_RD;
            end
         end
         S_ROOT: begin
            dp_cmd.set_result      = 1'b1;
            dp_cmd.result_status   = ST_OK;
            dp_cmd.result_from_ram = 1'b1;
            if (dp_status.cmd == CMD_PEEK) begin
               state_in = S_RESP;
            end else begin
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.rd_sel = RD_LAST;
               state_in      = S_LAST;
            end
         end
         S_LAST: begin
            dp_cmd.ld_extract = 1'b1;
            state_in          = S_DN_RD;
         end
         S_DN_RD: begin
            if (dp_status.no_child) begin
               dp_cmd.wr_en  = 1'b1;
               dp_cmd.wr_sel = WR_MOV;
               state_in      = S_RESP;
            end else begin
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.rd_sel = RD_LEFT;
               state_in      = S_DN_LEFT;
            end
         end
         S_DN_LEFT: begin
            dp_cmd.cval_ld = 1'b1;
            if (dp_status.has_right) begin
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.rd_sel = RD_RIGHT;
               state_in      = S_DN_RIGHT;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_RIGHT: begin
            // left wins a tie
            if (dp_status.right_lt) begin
               dp_cmd.cval_ld    = 1'b1;
               dp_cmd.cval_right = 1'b1;
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            dp_cmd.wr_en = 1'b1;
            if (dp_status.child_ge) begin
               dp_cmd.wr_sel = WR_MOV;
               state_in      = S_RESP;
            end else begin
               dp_cmd.wr_sel    = WR_CVAL;
               dp_cmd.pos_child = 1'b1;
               state_in         = S_DN_RD;
            end
         end
         S_RESP: begin
            if (dp_status.out_free) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/binary_min_heap_queue_top.sv
// Binary min-heap priority queue of signed keys (insert, extract minimum, peek).
// One item is taken at a time and gives one result word; the next is accepted
// only once the last one's word is loaded. Peek reads the root; insert moves up
// a level per parent comparison; extract reads the root and the last key, then
// moves down, reading the left and any right child per level; empty, full and
// unused commands go straight to the result. A finished word waits in an output
// register while the next item is accepted and worked on; a stalled word holds
// the block only when the next word is ready before it leaves. No clearing pass
// after reset. Depends on hmq_pkg, hmq_controller, hmq_datapath and hmq_ram.
module binary_min_heap_queue_top import hmq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   hmq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   hmq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

`ifndef SYNTHESIS
   // busy right after taking a word
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in flight");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_FULL) |->
         rsp_word.count_out == COUNT_W'(CAPACITY))
      else $error("full status without a full heap");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_EMPTY) |->
         (rsp_word.count_out == '0 && rsp_word.key_out == '0))
      else $error("empty status with keys held or nonzero key");
`endif

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for binary_min_heap_queue_top with random idling on both sides
// keeps its own heap copy to predict every result word; depends on hmq_pkg and the design files
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hmq_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

   class heap_order_model;
      key_type      keys [CAPACITY+1];
      int           held;
      rsp_word_type awaited_results [$];
      int           mismatches;

      function new();
         held = 0;
         mismatches = 0;
      endfunction

      function void exchange(int a, int b);
         key_type t;
         t = keys[a];
         keys[a] = keys[b];
         keys[b] = t;
      endfunction

      function void sift_up(int pos);
         int parent;
         while (pos > 1) begin
            parent = pos / 2;
            if (keys[parent] <= keys[pos]) break;
            exchange(parent, pos);
            pos = parent;
         end
      endfunction

      function void sift_down(int pos);
         int child;
         while (pos <= held / 2) begin
            child = pos * 2;
            if (child < held && keys[child] > keys[child+1]) child++;
            if (keys[child] >= keys[pos]) break;
            exchange(child, pos);
            pos = child;
         end
      endfunction

      task note_request(req_word_type w);
         rsp_word_type r;
         r.key_out = '0;
         r.status  = ST_OK;
         case (w.cmd)
            CMD_INSERT: begin
               if (held >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  held++;
                  keys[held] = w.key_in;
                  sift_up(held);
               end
            end
            CMD_EXTRACT, CMD_PEEK: begin
               if (held == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.key_out = keys[1];
                  if (w.cmd == CMD_EXTRACT) begin
                     keys[1] = keys[held];
                     held--;
                     sift_down(1);
                  end
               end
            end
            default: ;
         endcase
         r.count_out = COUNT_W'(held);
         awaited_results.push_back(r);
      endtask

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_response(rsp_word_type w);
         rsp_word_type e;
         if (awaited_results.size() == 0) begin
            report($sformatf("unexpected word key %0d count %0d status %0d",
                             w.key_out, w.count_out, w.status));
         end else begin
            e = awaited_results.pop_front();
            if (w.key_out !== e.key_out)
               report($sformatf("key_out %0d, want %0d", w.key_out, e.key_out));
            if (w.count_out !== e.count_out)
               report($sformatf("count_out %0d, want %0d", w.count_out, e.count_out));
            if (w.status !== e.status)
               report($sformatf("status %0d, want %0d", w.status, e.status));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   heap_order_model heap_model = new();
   int idle_odds = 0;
   int stall_left = 0;
   int stuck_cycles = 0;
   int tb_level = 0;

   binary_min_heap_queue_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || idle_odds == 0) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(1, idle_odds * 2) == 1) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
         else
            stuck_cycles <= stuck_cycles + 1;
         if (rsp_valid && !rsp_stall) heap_model.check_response(rsp_word);
         if (req_valid && !req_stall) heap_model.note_request(req_word);
      end
   end

   initial begin
      wait (stuck_cycles >= WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic key_type pick_key();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return {1'b0, {(KEY_WIDTH-1){1'b1}}};
               1: return {1'b1, {(KEY_WIDTH-1){1'b0}}};
               2: return '0;
               default: return '1;
            endcase
         end
         1, 2, 3: return key_type'($urandom_range(0, 16)) - key_type'(8);
         default: return key_type'($urandom);
      endcase
   endfunction

   task automatic push_word(input logic [1:0] op, input key_type key);
      int gap;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{cmd: op, key_in: key};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == CMD_INSERT && tb_level < CAPACITY) tb_level++;
      if (op == CMD_EXTRACT && tb_level > 0) tb_level--;
   endtask

   initial begin
      int target;
      int r;
      logic [1:0] op;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty heap, extremes, duplicates, unused command
      idle_odds = 4;
      push_word(CMD_PEEK, pick_key());
      push_word(CMD_EXTRACT, pick_key());
      push_word(CMD_UNUSED, '1);
      push_word(CMD_INSERT, 5);
      push_word(CMD_INSERT, {1'b0, {(KEY_WIDTH-1){1'b1}}});
      push_word(CMD_INSERT, {1'b1, {(KEY_WIDTH-1){1'b0}}});
      push_word(CMD_INSERT, -1);
      push_word(CMD_INSERT, 0);
      push_word(CMD_INSERT, 5);
      push_word(CMD_INSERT, 1);
      push_word(CMD_PEEK, '0);
      push_word(CMD_UNUSED, '0);
      repeat (7) push_word(CMD_EXTRACT, pick_key());
      push_word(CMD_EXTRACT, '0);
      push_word(CMD_PEEK, '1);

      // random mix, no idling in the last segments
      for (int seg = 0; seg < 13; seg++) begin
         if (seg >= 11)
            idle_odds = 0;
         else
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
         target = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(0, 40);
         repeat (50) begin
            r = $urandom_range(0, 99);
            if (r < 3)
               op = CMD_UNUSED;
            else if (r < 18)
               op = CMD_PEEK;
            else if (tb_level < target)
               op = (r < 75) ? CMD_INSERT : CMD_EXTRACT;
            else
               op = (r < 45) ? CMD_INSERT : CMD_EXTRACT;
            push_word(op, pick_key());
         end
      end
      req_valid <= 1'b0;

      while (heap_model.awaited_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (heap_model.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
